/* hw/rtl/chte_pkg.sv */
// Shared types and constants for the chained hash table engine.
// No dependencies; imported by chte_bucket_unit, chte_slot_store and the top level.
package chte_pkg;

	localparam int BUCKET_COUNT_DEF     = 128;
	localparam int SLOTS_PER_BUCKET_DEF = 8;
	localparam int KEY_W                = 32;
	localparam int VALUE_W              = 64;
	localparam int KIND_W               = 2;

	localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERASE = 2'd2;

	// bucket reduction sequencer
	typedef enum logic [1:0] {
		BU_IDLE,
		BU_SHIFT,
		BU_FOLD,
		BU_DONE
	} bu_state_t;

	// main engine sequencer
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_READ,
		ST_CMP,
		ST_ACT
	} eng_state_t;

	// slot store access controls
	typedef struct packed {
		logic rd_en;
		logic valid_we;
		logic valid_wd;
		logic key_we;
		logic pay_we;
	} slot_ctl_t;

endpackage

/* hw/rtl/chte_bucket_unit.sv */
// Iterative key-to-bucket reduction: sign-extended key modulo BUCKET_COUNT.
// One shared reciprocal-multiply residue step per key byte; depends on chte_pkg.
module chte_bucket_unit #(
	parameter int BUCKET_COUNT = chte_pkg::BUCKET_COUNT_DEF,
	parameter int BKW          = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [chte_pkg::KEY_W-1:0] key,
	output logic                              done,
	output logic [BKW-1:0]                    bucket
);
	import chte_pkg::*;

	localparam int NBW = $clog2(BUCKET_COUNT);
	// step operand: residue followed by the next key byte
	localparam int VW  = BKW + 8;
	localparam int SH  = VW + NBW;
	localparam int RCW = VW + 1;
	localparam int PW  = 2 * VW + 1;
	// rounded-up reciprocal: exact floor quotient for any VW-bit operand
	localparam longint unsigned RECIP =
		((64'd1 << SH) + 64'(BUCKET_COUNT) - 64'd1) / 64'(BUCKET_COUNT);
	localparam logic [RCW-1:0] RCP = RCW'(RECIP);
	// upper sign-extension word (all ones) contributes this residue
	localparam longint unsigned HI_MOD = 64'hFFFF_FFFF_0000_0000 % 64'(BUCKET_COUNT);
	localparam logic [VW-1:0] HI_REM    = VW'(HI_MOD);
	localparam logic [VW-1:0] NB        = VW'(BUCKET_COUNT);
	localparam logic [1:0]    LAST_STEP = 2'(KEY_W / 8 - 1);

	bu_state_t        st_q, st_d;
	logic [KEY_W-1:0] key_q;
	logic             neg_q;
	logic [1:0]       cnt_q;
	logic [BKW-1:0]   rem_q;

	logic [VW-1:0] op_in, quo, op_out;
	logic [PW-1:0] prod;

	// shared residue step; quotient is below 256 in both uses
	always_comb begin
		if (st_q == BU_FOLD) begin
			op_in = VW'(rem_q) + (neg_q ? HI_REM : '0);
		end else begin
			op_in = {rem_q, key_q[KEY_W-1 -: 8]};
		end
		prod   = PW'(op_in) * PW'(RCP);
		quo    = VW'(prod[SH +: 8]);
		op_out = op_in - quo * NB;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			BU_IDLE: begin
				if (start) st_d = BU_SHIFT;
			end
			BU_SHIFT: begin
				if (cnt_q == LAST_STEP) st_d = BU_FOLD;
			end
			BU_FOLD: st_d = BU_DONE;
			BU_DONE: st_d = BU_IDLE;
			default: st_d = BU_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BU_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			BU_IDLE: begin
				if (start) begin
					key_q <= key;
					neg_q <= key[KEY_W-1];
					cnt_q <= '0;
					rem_q <= '0;
				end
			end
			BU_SHIFT: begin
				rem_q <= op_out[BKW-1:0];
				key_q <= {key_q[KEY_W-9:0], 8'd0};
				cnt_q <= cnt_q + 2'd1;
			end
			BU_FOLD: rem_q <= op_out[BKW-1:0];
			default: ;
		endcase
	end

	assign done   = (st_q == BU_DONE);
	assign bucket = rem_q;

endmodule

/* hw/rtl/chte_slot_store.sv */
// Slot storage: valid bits, keys and payloads, one shared address port.
// Registered read data; depends on chte_pkg.
module chte_slot_store #(
	parameter int DEPTH = chte_pkg::BUCKET_COUNT_DEF * chte_pkg::SLOTS_PER_BUCKET_DEF,
	parameter int AW    = 10
) (
	input  logic                          clk,
	input  chte_pkg::slot_ctl_t           ctl,
	input  logic [AW-1:0]                 addr,
	input  logic [chte_pkg::KEY_W-1:0]    wr_key,
	input  logic [chte_pkg::VALUE_W-1:0]  wr_pay,
	output logic                          rd_valid,
	output logic [chte_pkg::KEY_W-1:0]    rd_key,
	output logic [chte_pkg::VALUE_W-1:0]  rd_pay
);
	import chte_pkg::*;

	logic               valid_mem [DEPTH];
	logic [KEY_W-1:0]   key_mem   [DEPTH];
	logic [VALUE_W-1:0] pay_mem   [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.valid_we) valid_mem[addr] <= ctl.valid_wd;
		if (ctl.rd_en)    rd_valid        <= valid_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.key_we) key_mem[addr] <= wr_key;
		if (ctl.rd_en)  rd_key        <= key_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.pay_we) pay_mem[addr] <= wr_pay;
		if (ctl.rd_en)  rd_pay        <= pay_mem[addr];
	end

endmodule

/* hw/rtl/chained_hash_table_engine.sv */
// Top level of the chained hash table engine: request sequencer and result register.
// Depends on chte_pkg, chte_bucket_unit and chte_slot_store.
//
// Usage:
//   Requests arrive on the s_ channel, one word each: s_tuser carries the kind
//   (get, put, erase), s_tdata the key and the payload. Each request yields one
//   result word on the m_ channel: hit flag, read payload and overflow status.
//   The key is reduced to its bucket one key byte per cycle by a shared
//   reciprocal-multiply residue step, then one fold step for the sign extension,
//   after which the bucket's slots are read and compared one at a time, a read
//   state then a compare state per slot, through a single memory port. A final
//   state writes back and loads the result register once that register is free.
// Flow: one request at a time, through the accept, the bucket reduction, the
//   per-slot read/compare loop and the write-back; s_tready is low meanwhile.
// Reset: arst_n clears all control state, then a clearing pass writes every
//   valid bit to zero with s_tready low.
// Stall: a result waits in the output register while m_tready is low; the next
//   request is still accepted and worked on, and only its write-back waits until
//   the register is free.
module chained_hash_table_engine #(
	parameter int BUCKET_COUNT     = chte_pkg::BUCKET_COUNT_DEF,
	parameter int SLOTS_PER_BUCKET = chte_pkg::SLOTS_PER_BUCKET_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// request channel
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,  // [31:0] key (signed), [95:32] value
	input  logic [1:0]   s_tuser,  // [1:0] kind
	// result channel
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [71:0]  m_tdata   // [0] hit, [64:1] read_value, [65] status, rest zero
);
	import chte_pkg::*;

	localparam int TOTAL = BUCKET_COUNT * SLOTS_PER_BUCKET;
	localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
	localparam int BKW   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int SLW   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
	localparam logic [AW-1:0]  LAST_ADDR = AW'(TOTAL - 1);
	localparam logic [SLW-1:0] LAST_SLOT = SLW'(SLOTS_PER_BUCKET - 1);
	localparam int OUT_W = 2 + VALUE_W;

	eng_state_t         st_q, st_d;
	logic [KIND_W-1:0]  kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [VALUE_W-1:0] value_q;
	logic [AW-1:0]      addr_q;
	logic [SLW-1:0]     slot_q;
	logic               match_f_q, free_f_q;
	logic [AW-1:0]      match_addr_q, free_addr_q;
	logic [VALUE_W-1:0] match_pay_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_data_q;

	// bucket unit link
	logic           bu_start, bu_done;
	logic [BKW-1:0] bu_bucket;

	// slot store link
	slot_ctl_t          ctl;
	logic [AW-1:0]      mem_addr;
	logic               rd_valid;
	logic [KEY_W-1:0]   rd_key;
	logic [VALUE_W-1:0] rd_pay;

	// result of the write-back step
	logic               load_out;
	logic               hit_d, status_d;
	logic [VALUE_W-1:0] rd_d;

	chte_bucket_unit #(
		.BUCKET_COUNT(BUCKET_COUNT),
		.BKW         (BKW)
	) u_bucket (
		.clk   (clk),
		.arst_n(arst_n),
		.start (bu_start),
		.key   (s_tdata[KEY_W-1:0]),
		.done  (bu_done),
		.bucket(bu_bucket)
	);

	chte_slot_store #(
		.DEPTH(TOTAL),
		.AW   (AW)
	) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.addr    (mem_addr),
		.wr_key  (key_q),
		.wr_pay  (value_q),
		.rd_valid(rd_valid),
		.rd_key  (rd_key),
		.rd_pay  (rd_pay)
	);

	// sequencer: next state and strobes
	always_comb begin
		st_d     = st_q;
		ctl      = '0;
		mem_addr = addr_q;
		bu_start = 1'b0;
		load_out = 1'b0;
		hit_d    = 1'b0;
		status_d = 1'b0;
		rd_d     = '0;
		case (st_q)
			ST_CLEAR: begin
				ctl.valid_we = 1'b1;
				if (addr_q == LAST_ADDR) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					bu_start = 1'b1;
					st_d     = ST_HASH;
				end
			end
			ST_HASH: begin
				if (bu_done) st_d = ST_READ;
			end
			ST_READ: begin
				ctl.rd_en = 1'b1;
				st_d      = ST_CMP;
			end
			ST_CMP: begin
				st_d = (slot_q == LAST_SLOT) ? ST_ACT : ST_READ;
			end
			ST_ACT: begin
				mem_addr = match_f_q ? match_addr_q : free_addr_q;
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					st_d     = ST_IDLE;
					case (kind_q)
						KIND_GET: begin
							if (match_f_q) begin
								hit_d = 1'b1;
								rd_d  = match_pay_q;
							end
						end
						KIND_PUT: begin
							if (match_f_q) begin
								hit_d      = 1'b1;
								ctl.pay_we = 1'b1;
							end else if (free_f_q) begin
								ctl.valid_we = 1'b1;
								ctl.valid_wd = 1'b1;
								ctl.key_we   = 1'b1;
								ctl.pay_we   = 1'b1;
							end else begin
								status_d = 1'b1;
							end
						end
						KIND_ERASE: begin
							if (match_f_q) begin
								hit_d        = 1'b1;
								ctl.valid_we = 1'b1;
							end
						end
						default: ;  // unused kind: no change, all-zero result
					endcase
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_CLEAR;
			addr_q     <= '0;
			slot_q     <= '0;
			match_f_q  <= 1'b0;
			free_f_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			case (st_q)
				ST_CLEAR: begin
					if (addr_q != LAST_ADDR) addr_q <= addr_q + 1'b1;
				end
				ST_HASH: begin
					if (bu_done) begin
						addr_q    <= AW'(bu_bucket * SLOTS_PER_BUCKET);
						slot_q    <= '0;
						match_f_q <= 1'b0;
						free_f_q  <= 1'b0;
					end
				end
				ST_CMP: begin
					// keys are unique within a bucket; keep the first match and first hole
					if (rd_valid) begin
						if (!match_f_q && rd_key == key_q) match_f_q <= 1'b1;
					end else if (!free_f_q) begin
						free_f_q <= 1'b1;
					end
					if (slot_q != LAST_SLOT) begin
						slot_q <= slot_q + 1'b1;
						addr_q <= addr_q + 1'b1;
					end
				end
				default: ;
			endcase
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && s_tvalid) begin
			kind_q  <= s_tuser;
			key_q   <= s_tdata[KEY_W-1:0];
			value_q <= s_tdata[KEY_W +: VALUE_W];
		end
		if (st_q == ST_CMP) begin
			if (rd_valid && !match_f_q && rd_key == key_q) begin
				match_addr_q <= addr_q;
				match_pay_q  <= rd_pay;
			end
			if (!rd_valid && !free_f_q) free_addr_q <= addr_q;
		end
		if (load_out) m_data_q <= {status_d, rd_d, hit_d};
	end

	assign s_tready = (st_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(72 - OUT_W){1'b0}}, m_data_q};

endmodule
